// ===== src/jsri_pkg.sv =====
// shared types and constants of the jpeg stuffing and restart inserter
package jsri_pkg;

  localparam int unsigned RESTART_DEPTH = 256;
  localparam int unsigned POSITION_BITS = 32;
  localparam int unsigned HEAD_W  = $clog2(RESTART_DEPTH);
  localparam int unsigned COUNT_W = $clog2(RESTART_DEPTH + 1);
  localparam int unsigned TAIL_W  = COUNT_W + 1;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0]  MARKER_BYTE = 8'hFF;
  localparam logic [7:0]  RST_BASE    = 8'hD0;
  localparam logic [7:0]  STUFF_BYTE  = 8'h00;
  localparam logic [15:0] MIS_MAX     = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_START = 2'd1,
    OP_END   = 2'd2,
    OP_LOAD  = 2'd3
  } op_e;

  typedef enum logic {
    FR_IDLE,
    FR_EXEC
  } fr_state_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DATA,
    BK_STUFF,
    BK_MFF,
    BK_MCODE
  } bk_state_e;

  // one unit of output work: an optional coded byte then a run of markers
  typedef struct packed {
    logic       is_byte;
    logic [7:0] data;
    logic [4:0] n_markers;
    logic [2:0] cycle;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== src/jsri_fifo.sv =====
// small command queue between the front and back parts
module jsri_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  jsri_pkg::cmd_t      cmd_i,
  input  logic                pop_i,
  output jsri_pkg::cmd_t      cmd_o,
  output jsri_pkg::fifo_stat_t stat_o
);

  jsri_pkg::cmd_t                      mem_q [jsri_pkg::FIFO_DEPTH];
  logic [jsri_pkg::FIFO_PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [jsri_pkg::FIFO_PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [jsri_pkg::FIFO_CNT_W-1:0]     cnt_q, cnt_d;
  logic                                do_push, do_pop;

  assign stat_o.full  = (cnt_q == jsri_pkg::FIFO_CNT_W'(jsri_pkg::FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == jsri_pkg::FIFO_PTR_W'(jsri_pkg::FIFO_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == jsri_pkg::FIFO_PTR_W'(jsri_pkg::FIFO_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= cmd_i;
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= jsri_pkg::FIFO_CNT_W'(jsri_pkg::FIFO_DEPTH))
    else $error("fifo count above depth");
`endif

endmodule

// ===== src/jsri_front.sv =====
// front part: accepts items, keeps the restart queue and scan state
module jsri_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           op_i,
  input  logic [7:0]           data_byte_i,
  input  logic [15:0]          restart_limit_i,
  input  logic [31:0]          position_i,
  input  logic [4:0]           false_markers_i,
  input  jsri_pkg::fifo_stat_t fifo_stat_i,
  output logic                 push_o,
  output jsri_pkg::cmd_t       cmd_o
);

  localparam int unsigned PB = jsri_pkg::POSITION_BITS;

  jsri_pkg::fr_state_e state_q, state_d;

  // latched item
  jsri_pkg::op_e  op_q;
  logic [7:0]     data_q;
  logic [15:0]    limit_q;
  logic [PB-1:0]  pos_q;
  logic [4:0]     extra_q;

  logic [PB-1:0]  qmem [jsri_pkg::RESTART_DEPTH];
  logic [PB-1:0]  rd_q;

  logic [jsri_pkg::HEAD_W-1:0]  head_q, head_d;
  logic [jsri_pkg::COUNT_W-1:0] count_q, count_d;
  logic [PB-1:0]                bpos_q, bpos_d;
  logic [2:0]                   cyc_q, cyc_d;
  logic [15:0]                  mis_q, mis_d;
  logic [15:0]                  slim_q, slim_d;

  logic                         accept, need_push, done, match, wr_en;
  logic [jsri_pkg::TAIL_W-1:0]  tail_sum;
  logic [jsri_pkg::HEAD_W-1:0]  tail;

  assign accept = in_valid_i && in_ready_o;

  assign tail_sum = jsri_pkg::TAIL_W'(head_q) + jsri_pkg::TAIL_W'(count_q);
  assign tail = (tail_sum >= jsri_pkg::TAIL_W'(jsri_pkg::RESTART_DEPTH)) ?
                jsri_pkg::HEAD_W'(tail_sum - jsri_pkg::TAIL_W'(jsri_pkg::RESTART_DEPTH)) :
                jsri_pkg::HEAD_W'(tail_sum);

  assign match = (count_q != '0) && (rd_q == bpos_q) &&
                 ((slim_q == '0) || (mis_q < slim_q));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      jsri_pkg::FR_IDLE: if (accept) state_d = jsri_pkg::FR_EXEC;
      jsri_pkg::FR_EXEC: if (done) state_d = jsri_pkg::FR_IDLE;
      default:           state_d = jsri_pkg::FR_IDLE;
    endcase
  end

  // outputs and state updates
  always_comb begin
    in_ready_o = 1'b0;
    need_push  = 1'b0;
    wr_en      = 1'b0;
    cmd_o      = '0;
    head_d     = head_q;
    count_d    = count_q;
    bpos_d     = bpos_q;
    cyc_d      = cyc_q;
    mis_d      = mis_q;
    slim_d     = slim_q;
    case (state_q)
      jsri_pkg::FR_IDLE: begin
        in_ready_o = 1'b1;
      end
      jsri_pkg::FR_EXEC: begin
        case (op_q)
          jsri_pkg::OP_BYTE: begin
            need_push       = 1'b1;
            cmd_o.is_byte   = 1'b1;
            cmd_o.data      = data_q;
            cmd_o.n_markers = match ? 5'd1 : 5'd0;
            cmd_o.cycle     = cyc_q;
            if (match) begin
              head_d  = (head_q == jsri_pkg::HEAD_W'(jsri_pkg::RESTART_DEPTH - 1)) ?
                        '0 : head_q + 1'b1;
              count_d = count_q - 1'b1;
              cyc_d   = cyc_q + 3'd1;
              if (mis_q != jsri_pkg::MIS_MAX) mis_d = mis_q + 16'd1;
            end
            bpos_d = bpos_q + 1'b1;
          end
          jsri_pkg::OP_START: begin
            cyc_d  = '0;
            mis_d  = '0;
            slim_d = limit_q;
          end
          jsri_pkg::OP_END: begin
            need_push       = (extra_q != '0);
            cmd_o.is_byte   = 1'b0;
            cmd_o.data      = data_q;
            cmd_o.n_markers = extra_q;
            cmd_o.cycle     = cyc_q;
            cyc_d           = cyc_q + extra_q[2:0];
            mis_d           = '0;
          end
          jsri_pkg::OP_LOAD: begin
            if (count_q < jsri_pkg::COUNT_W'(jsri_pkg::RESTART_DEPTH)) begin
              wr_en   = 1'b1;
              count_d = count_q + 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign done   = (state_q == jsri_pkg::FR_EXEC) && (!need_push || !fifo_stat_i.full);
  assign push_o = (state_q == jsri_pkg::FR_EXEC) && need_push && !fifo_stat_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jsri_pkg::FR_IDLE;
      head_q  <= '0;
      count_q <= '0;
      bpos_q  <= '0;
      cyc_q   <= '0;
      mis_q   <= '0;
      slim_q  <= '0;
    end else begin
      state_q <= state_d;
      if (done) begin
        head_q  <= head_d;
        count_q <= count_d;
        bpos_q  <= bpos_d;
        cyc_q   <= cyc_d;
        mis_q   <= mis_d;
        slim_q  <= slim_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= jsri_pkg::op_e'(op_i);
      data_q  <= data_byte_i;
      limit_q <= restart_limit_i;
      pos_q   <= PB'(position_i);
      extra_q <= false_markers_i;
    end
  end

  // restart position memory, read data registered
  always_ff @(posedge clk_i) begin
    if (done && wr_en) qmem[tail] <= pos_q;
    rd_q <= qmem[head_q];
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= jsri_pkg::COUNT_W'(jsri_pkg::RESTART_DEPTH))
    else $error("restart queue count above depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (state_q == jsri_pkg::FR_EXEC) && !fifo_stat_i.full)
    else $error("push into full queue or outside exec");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == jsri_pkg::FR_EXEC) && done |=> in_ready_o)
    else $error("front did not return to idle");
`endif

endmodule

// ===== src/jsri_back.sv =====
// back part: expands commands into output bytes behind an output register
module jsri_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  jsri_pkg::cmd_t       cmd_i,
  input  jsri_pkg::fifo_stat_t fifo_stat_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 last_o
);

  jsri_pkg::bk_state_e state_q, state_d;

  logic [7:0] data_q;
  logic [4:0] rem_q;
  logic [2:0] cyc_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       valid_q;

  logic       advance, emit;
  logic [7:0] nbyte;
  logic       nlast;

  assign advance = !valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      jsri_pkg::BK_IDLE: begin
        if (!fifo_stat_i.empty) state_d = cmd_i.is_byte ? jsri_pkg::BK_DATA : jsri_pkg::BK_MFF;
      end
      jsri_pkg::BK_DATA: begin
        if (advance) begin
          if (data_q == jsri_pkg::MARKER_BYTE) state_d = jsri_pkg::BK_STUFF;
          else if (rem_q != '0)                state_d = jsri_pkg::BK_MFF;
          else                                 state_d = jsri_pkg::BK_IDLE;
        end
      end
      jsri_pkg::BK_STUFF: begin
        if (advance) state_d = (rem_q != '0) ? jsri_pkg::BK_MFF : jsri_pkg::BK_IDLE;
      end
      jsri_pkg::BK_MFF: begin
        if (advance) state_d = jsri_pkg::BK_MCODE;
      end
      jsri_pkg::BK_MCODE: begin
        if (advance) state_d = (rem_q > 5'd1) ? jsri_pkg::BK_MFF : jsri_pkg::BK_IDLE;
      end
      default: state_d = jsri_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_o = 1'b0;
    emit  = 1'b0;
    nbyte = jsri_pkg::STUFF_BYTE;
    nlast = 1'b0;
    case (state_q)
      jsri_pkg::BK_IDLE: begin
        pop_o = !fifo_stat_i.empty;
      end
      jsri_pkg::BK_DATA: begin
        emit  = advance;
        nbyte = data_q;
        nlast = (data_q != jsri_pkg::MARKER_BYTE) && (rem_q == '0);
      end
      jsri_pkg::BK_STUFF: begin
        emit  = advance;
        nbyte = jsri_pkg::STUFF_BYTE;
        nlast = (rem_q == '0);
      end
      jsri_pkg::BK_MFF: begin
        emit  = advance;
        nbyte = jsri_pkg::MARKER_BYTE;
      end
      jsri_pkg::BK_MCODE: begin
        emit  = advance;
        nbyte = jsri_pkg::RST_BASE + 8'(cyc_q);
        nlast = (rem_q == 5'd1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jsri_pkg::BK_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit)             valid_q <= 1'b1;
      else if (out_ready_i) valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= cmd_i.data;
      rem_q  <= cmd_i.n_markers;
      cyc_q  <= cmd_i.cycle;
    end else if (emit && (state_q == jsri_pkg::BK_MCODE)) begin
      rem_q <= rem_q - 5'd1;
      cyc_q <= cyc_q + 3'd1;
    end
    if (emit) begin
      byte_q <= nbyte;
      last_q <= nlast;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == jsri_pkg::BK_MFF || state_q == jsri_pkg::BK_MCODE) |-> rem_q != '0)
    else $error("marker state with no markers left");
`endif

endmodule

// ===== src/jpeg_stuff_restart_inserter.sv =====
// top level of the jpeg byte stuffing and restart marker inserter
//
// input channel (in_valid_i / in_ready_o): one beat per command. op 0 sends a
// coded byte, op 1 starts a scan and takes the marker limit (0 = unlimited),
// op 2 ends a scan and appends false_markers extra restart markers, op 3 loads
// a restart position into the queue (ignored when the queue is full).
// output channel (out_valid_o / out_ready_i): one beat per output byte, with
// last_o high on the final byte caused by a command. op 1 and op 3, and op 2
// with no extra markers, produce no beats.
// throughput: the front takes one command at a time (accept in idle, then
// compare with the registered restart queue head and update state in exec,
// waiting there while the command queue is full). the back fetches a command
// from the 4-entry queue in idle, then sends one byte per cycle while the
// receiver is ready: 1 to 4 bytes for a coded byte, 2 per marker for an end
// of scan (up to 62). a command's first byte passes front exec, the command
// queue, back idle and the output register when both parts are free.
// reset clears the queue pointers, scan counters, byte position and both
// state machines; the restart memory itself is not cleared.
// a stalled receiver holds the output register; the back stops, the command
// queue fills and then the front holds in_ready_o low.
module jpeg_stuff_restart_inserter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] restart_limit_i,
  input  logic [31:0] position_i,
  input  logic [4:0]  false_markers_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);

  jsri_pkg::cmd_t       push_cmd, pop_cmd;
  jsri_pkg::fifo_stat_t fifo_stat;
  logic                 push, pop;

  // front: classify the command, match restart positions, update scan state
  jsri_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .data_byte_i     (data_byte_i),
    .restart_limit_i (restart_limit_i),
    .position_i      (position_i),
    .false_markers_i (false_markers_i),
    .fifo_stat_i     (fifo_stat),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  // decoupling queue of output work
  jsri_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (pop_cmd),
    .stat_o (fifo_stat)
  );

  // back: byte sequencer with stuffing and marker expansion
  jsri_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (pop_cmd),
    .fifo_stat_i (fifo_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_stat.empty)
    else $error("pop from empty command queue");
`endif

endmodule
